@@ hw/rtl/sha_pkg.sv @@
package sha_pkg;

   localparam int BLK_WORDS = 16;
   localparam int ROUNDS   = 64;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] v;
      begin
         unique case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
         endcase
         return v;
      end
   endfunction

   function automatic logic [31:0] kround(input logic [5:0] t);
      logic [31:0] k [64];
      begin
         k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
         return k[t];
      end
   endfunction

endpackage

@@ hw/rtl/sha256_stream_hasher_unit.sv @@
// SHA-256 hasher over a byte stream.
// Input words arrive on req_valid/req_ready carrying req_data_byte,
// req_byte_valid and req_last. Bytes are packed big-endian into 32-bit
// message words and written into the schedule RAM of the compression
// engine, each word once its fourth byte is taken in the idle state.
// When the 64th byte of a block is taken the engine runs 64 rounds
// (four reads through the single read port of that RAM, one write back
// and one round update), so req_ready stays low until that compression
// is done; every other byte is taken without a stall.
// A word with req_last set pads the message: each remaining byte
// position in turn is written with 0x80, zeros and the 64-bit bit
// length, then the block is compressed. If the length no longer fits, a
// second block of padding and compression follows. Eight digest words
// are then offered on rsp_valid/rsp_ready, word 0 first, one per cycle
// while the receiver is ready. A stalled receiver simply holds the
// current digest word; no input is taken until all eight are delivered.
// The chaining state then returns to the initial values. Reset is
// synchronous and returns the block to idle with the initial hash and a
// zero byte count; no clearing pass is needed.
module sha256_stream_hasher_unit
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   state_type    st_ff, st_in;
   logic [255:0] hash_ff, hash_in;
   logic [63:0]  cnt_ff, cnt_in;
   logic [5:0]   fill_ff, fill_in;
   logic [23:0]  part_ff, part_in;
   logic         mark_ff, mark_in;
   logic         len_blk_ff, len_blk_in;
   logic         pad_ff, pad_in;
   logic         fin_ff, fin_in;
   logic [2:0]   idx_ff, idx_in;
   logic         ld_en;
   logic [3:0]   ld_addr;
   logic [31:0]  ld_data;
   logic         start;
   logic [255:0] hout;
   logic         done;
   logic [63:0]  bits;
   logic [5:0]   len_lsb;
   logic [7:0]   pb;

   sha_core u_core (
      .clock(clock), .reset(reset), .start(start),
      .ld_en(ld_en), .ld_addr(ld_addr), .ld_data(ld_data),
      .hin(hash_ff), .hout(hout), .done(done)
   );

   // The message length in bits wraps modulo 2^64 with the byte count.
   assign bits    = {cnt_ff[60:0], 3'b000};
   assign len_lsb = {3'd7 - fill_ff[2:0], 3'b000};

   // Padding byte for the current position. mark_ff means the 0x80 byte
   // still has to be placed; len_blk_ff means this block ends with the
   // length, most significant byte at position 56.
   always_comb begin
      if (mark_ff) pb = PAD_MARK;
      else if (len_blk_ff && fill_ff >= LEN_POS) pb = bits[len_lsb +: 8];
      else pb = 8'h00;
   end

   always_comb begin
      st_in = st_ff; hash_in = hash_ff; cnt_in = cnt_ff; fill_in = fill_ff;
      part_in = part_ff; mark_in = mark_ff; len_blk_in = len_blk_ff;
      pad_in = pad_ff; fin_in = fin_ff; idx_in = idx_ff;
      ld_en = 1'b0; ld_addr = fill_ff[5:2]; ld_data = '0;
      start = 1'b0; req_ready = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_byte_valid) begin
                  cnt_in = cnt_ff + 64'd1;
                  fill_in = fill_ff + 6'd1;
                  part_in = {part_ff[15:0], req_data_byte};
                  if (fill_ff[1:0] == 2'd3) begin
                     ld_en = 1'b1;
                     ld_data = {part_ff, req_data_byte};
                  end
                  if (fill_ff == 6'd63) begin
                     // A last byte that fills the block puts all padding
                     // into a fresh block after this compression.
                     start = 1'b1;
                     st_in = ST_ROUND;
                     fin_in = 1'b0;
                     pad_in = req_last;
                     mark_in = req_last;
                     len_blk_in = req_last;
                  end else if (req_last) begin
                     st_in = ST_PAD; pad_in = 1'b1; mark_in = 1'b1;
                     len_blk_in = (fill_ff + 6'd1 < LEN_POS);
                  end
               end else if (req_last) begin
                  st_in = ST_PAD; pad_in = 1'b1; mark_in = 1'b1;
                  len_blk_in = (fill_ff < LEN_POS);
               end
            end
         end
         ST_PAD: begin
            mark_in = 1'b0;
            fill_in = fill_ff + 6'd1;
            part_in = {part_ff[15:0], pb};
            if (fill_ff[1:0] == 2'd3) begin
               ld_en = 1'b1;
               ld_data = {part_ff, pb};
            end
            if (fill_ff == 6'd63) begin
               start = 1'b1; st_in = ST_ROUND; fin_in = len_blk_ff;
            end
         end
         ST_ROUND: begin
            if (done) begin
               hash_in = hout;
               if (fin_ff) begin
                  st_in = ST_EMIT; idx_in = '0;
               end else if (pad_ff) begin
                  // The length goes into the next block.
                  st_in = ST_PAD; len_blk_in = 1'b1;
               end else begin
                  st_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  st_in = ST_IDLE;
                  for (int i = 0; i < 8; i++) hash_in[255 - 32*i -: 32] = init_hash(3'(i));
                  cnt_in = '0; fill_in = '0; pad_in = 1'b0; fin_in = 1'b0;
                  mark_in = 1'b0; len_blk_in = 1'b0;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         for (int i = 0; i < 8; i++) hash_ff[255 - 32*i -: 32] <= init_hash(3'(i));
         cnt_ff <= '0; fill_ff <= '0; mark_ff <= 1'b0; len_blk_ff <= 1'b0;
         pad_ff <= 1'b0; fin_ff <= 1'b0; idx_ff <= '0; part_ff <= '0;
      end else begin
         st_ff <= st_in; hash_ff <= hash_in; cnt_ff <= cnt_in; fill_ff <= fill_in;
         mark_ff <= mark_in; len_blk_ff <= len_blk_in; pad_ff <= pad_in;
         fin_ff <= fin_in; idx_ff <= idx_in; part_ff <= part_in;
      end
   end

   assign rsp_valid       = (st_ff == ST_EMIT);
   assign rsp_digest_word = hash_ff[255 - 32*idx_ff -: 32];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   a_no_req_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken during digest");
   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word_index)) else $error("index moved");
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid) else $error("extra word");

endmodule

@@ hw/rtl/sha_ram.sv @@
module sha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sha_core.sv @@
// Compression engine. The sixteen message words sit in a 16-entry RAM
// that doubles as the rolling schedule window. Each round steps through
// reads of w[t-15], w[t-2], w[t-7] and the slot itself on the single
// read port, forming the new word and writing it back, and then the
// round update.
module sha_core
   import sha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         ld_en,
   input  logic [3:0]   ld_addr,
   input  logic [31:0]  ld_data,
   input  logic [255:0] hin,
   output logic [255:0] hout,
   output logic         done
);

   localparam logic [2:0] PH_ADDR15   = 3'd0;
   localparam logic [2:0] PH_ADDR2    = 3'd1;
   localparam logic [2:0] PH_ADDR7    = 3'd2;
   localparam logic [2:0] PH_ADDRSLOT = 3'd3;
   localparam logic [2:0] PH_WORD     = 3'd4;
   localparam logic [2:0] PH_ROUND    = 3'd5;

   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [5:0]  t_ff;
   logic [2:0]  ph_ff;
   logic        run_ff;
   logic        done_ff;
   logic [31:0] w15_ff, w2_ff, pre_ff, w_ff;
   logic [3:0]  rd_addr;
   logic [31:0] rd_data;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;
   logic [31:0] w_new, s0, s1, big0, big1, ch, maj, x1, x2;

   sha_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_win (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      case (ph_ff)
         PH_ADDR15: rd_addr = t_ff[3:0] - 4'd15;
         PH_ADDR2:  rd_addr = t_ff[3:0] - 4'd2;
         PH_ADDR7:  rd_addr = t_ff[3:0] - 4'd7;
         default:   rd_addr = t_ff[3:0];
      endcase
   end

   always_comb begin
      s0 = {w15_ff[6:0], w15_ff[31:7]} ^ {w15_ff[17:0], w15_ff[31:18]}
           ^ (w15_ff >> 3);
      s1 = {w2_ff[16:0], w2_ff[31:17]} ^ {w2_ff[18:0], w2_ff[31:19]}
           ^ (w2_ff >> 10);
      w_new = (t_ff < 6'd16) ? rd_data : rd_data + pre_ff;
      big1 = {e_ff[5:0], e_ff[31:6]} ^ {e_ff[10:0], e_ff[31:11]}
             ^ {e_ff[24:0], e_ff[31:25]};
      ch   = (e_ff & f_ff) ^ (~e_ff & g_ff);
      x1   = h_ff + big1 + ch + kround(t_ff) + w_ff;
      big0 = {a_ff[1:0], a_ff[31:2]} ^ {a_ff[12:0], a_ff[31:13]}
             ^ {a_ff[21:0], a_ff[31:22]};
      maj  = (a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff);
      x2   = big0 + maj;
   end

   // The top level only loads words while the engine is idle.
   assign wr_en   = ld_en | (run_ff && ph_ff == PH_WORD);
   assign wr_addr = ld_en ? ld_addr : t_ff[3:0];
   assign wr_data = ld_en ? ld_data : w_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; ph_ff <= PH_ADDR15; t_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1; ph_ff <= PH_ADDR15; t_ff <= '0;
         end else if (run_ff) begin
            if (ph_ff == PH_ROUND) begin
               ph_ff <= PH_ADDR15;
               t_ff  <= t_ff + 6'd1;
               if (t_ff == 6'(ROUNDS - 1)) begin
                  run_ff <= 1'b0; done_ff <= 1'b1;
               end
            end else begin
               ph_ff <= ph_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (run_ff && ph_ff == PH_ADDR2) w15_ff <= rd_data;
      if (run_ff && ph_ff == PH_ADDR7) w2_ff <= rd_data;
      if (run_ff && ph_ff == PH_ADDRSLOT) pre_ff <= s0 + s1 + rd_data;
      if (run_ff && ph_ff == PH_WORD) w_ff <= w_new;
      if (start) begin
         {a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff} <= hin;
      end else if (run_ff && ph_ff == PH_ROUND) begin
         h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + x1;
         d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= x1 + x2;
      end
   end

   assign hout = {hin[255:224] + a_ff, hin[223:192] + b_ff, hin[191:160] + c_ff,
                  hin[159:128] + d_ff, hin[127:96] + e_ff, hin[95:64] + f_ff,
                  hin[63:32] + g_ff, hin[31:0] + h_ff};
   assign done = done_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> !run_ff) else $error("core still running at done");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff) else $error("start while running");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ld_en |-> !run_ff) else $error("word load while running");

endmodule

@@ verif/tb.sv @@
module tb
   import sha_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Clock, reset and the ports of the hasher.
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_stream_hasher_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_byte_valid(req_byte_valid),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   // One expected digest word as it should appear on the result channel.
   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_word_type;

   // One word on the input channel. A nonzero first_digest_word in a
   // directed row is a known answer for digest word 0 of that message.
   typedef struct {
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic        last;
      logic [31:0] first_digest_word;
   } req_word_type;

   localparam int MAX_CYCLES = 2_000_000;
   localparam int ITEM_TARGET = 370;

   // Known answers: word 0 of SHA-256("") and SHA-256("abc").
   localparam logic [31:0] EMPTY_DIGEST_W0 = 32'he3b0c442;
   localparam logic [31:0] ABC_DIGEST_W0   = 32'hba7816bf;

   // The predictor's own copy of the hasher's state.
   logic [31:0] chain_hash [8];
   logic [7:0]  msg_block [64];
   logic [63:0] msg_bytes;
   logic [6:0]  block_fill;

   digest_word_type digest_queue[$];
   req_word_type    stim_words[$];
   int              fail_count;
   int              cycle_count;
   bit              stim_done;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   // Runs the 64 rounds of compression on msg_block into chain_hash.
   task automatic compress_msg_block();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, g, h, w, s0, s1, x1, x2;
      a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
      e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            w = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
         end else begin
            s0 = rotr(sched[(t-15)%16], 7) ^ rotr(sched[(t-15)%16], 18)
                 ^ (sched[(t-15)%16] >> 3);
            s1 = rotr(sched[(t-2)%16], 17) ^ rotr(sched[(t-2)%16], 19)
                 ^ (sched[(t-2)%16] >> 10);
            w = sched[t%16] + s0 + sched[(t-7)%16] + s1;
         end
         sched[t%16] = w;
         x1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + kround(t[5:0]) + w;
         x2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + x1;
         d = c; c = b; b = a; a = x1 + x2;
      end
      chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
      chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) chain_hash[i] = init_hash(i[2:0]);
      msg_bytes  = '0;
      block_fill = '0;
   endtask

   // Applies one accepted input word and queues any digest words it yields.
   task automatic predict_digest(input req_word_type rw);
      logic [63:0]     bit_len;
      int              pos;
      digest_word_type dw;
      if (rw.byte_valid) begin
         msg_block[block_fill[5:0]] = rw.data_byte;
         msg_bytes  = msg_bytes + 64'd1;
         block_fill = block_fill + 7'd1;
         if (block_fill == 7'd64) begin
            compress_msg_block();
            block_fill = '0;
         end
      end
      if (rw.last) begin
         bit_len = msg_bytes << 3;
         pos = block_fill;
         msg_block[pos] = PAD_MARK;
         pos++;
         if (pos > LEN_POS) begin
            while (pos < 64) msg_block[pos++] = 8'h00;
            compress_msg_block();
            pos = 0;
         end
         while (pos < LEN_POS) msg_block[pos++] = 8'h00;
         for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
         compress_msg_block();
         if (rw.first_digest_word != 0 && rw.first_digest_word != chain_hash[0]) begin
            $error("known answer digest_word: expected %h, actual %h",
                   rw.first_digest_word, chain_hash[0]);
            fail_count++;
         end
         for (int i = 0; i < 8; i++) begin
            dw.digest_word = chain_hash[i];
            dw.word_index  = i[2:0];
            dw.last_word   = (i == 7);
            digest_queue.push_back(dw);
         end
         restart_hash();
      end
   endtask

   function automatic req_word_type mk_word(input logic [7:0] d, input logic bv,
                                            input logic l, input logic [31:0] kat = '0);
      req_word_type rw;
      rw.data_byte = d; rw.byte_valid = bv; rw.last = l; rw.first_digest_word = kat;
      return rw;
   endfunction

   // Queues a message of n random bytes, with a few stray non-byte words
   // sprinkled in if noisy, ending in the final byte or a bare last word.
   task automatic add_message(input int n, input bit noisy);
      bit last_on_byte;
      last_on_byte = (n > 0) && $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 7) == 0)
            stim_words.push_back(mk_word(8'($urandom), 1'b0, 1'b0));
         stim_words.push_back(mk_word(8'($urandom), 1'b1, last_on_byte && i == n - 1));
      end
      if (!last_on_byte) stim_words.push_back(mk_word(8'($urandom), 1'b0, 1'b1));
   endtask

   // Drives stimulus. The directed rows come first: the empty message,
   // "abc", bytes at both extremes, a bare non-byte word, and lengths
   // around the padding boundary (with 55 bytes the length still fits, at
   // 56 it no longer fits and a second block is needed) and a full block.
   initial begin
      req_word_type rw;
      int           gap;
      int           msg_len;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_byte_valid = 1'b0;
      req_last       = 1'b0;
      fail_count     = 0;
      cycle_count    = 0;
      stim_done      = 1'b0;
      restart_hash();
      for (int i = 0; i < 64; i++) msg_block[i] = '0;

      stim_words.push_back(mk_word(8'hff, 1'b0, 1'b1, EMPTY_DIGEST_W0));
      stim_words.push_back(mk_word(8'h61, 1'b1, 1'b0));
      stim_words.push_back(mk_word(8'h00, 1'b0, 1'b0));
      stim_words.push_back(mk_word(8'h62, 1'b1, 1'b0));
      stim_words.push_back(mk_word(8'h63, 1'b1, 1'b1, ABC_DIGEST_W0));
      stim_words.push_back(mk_word(8'h00, 1'b1, 1'b0));
      stim_words.push_back(mk_word(8'hff, 1'b1, 1'b1));
      stim_words.push_back(mk_word(8'hff, 1'b1, 1'b0));
      stim_words.push_back(mk_word(8'h00, 1'b0, 1'b1));
      add_message(55, 1'b0);
      add_message(56, 1'b0);
      add_message(64, 1'b0);

      // Random part: mostly short messages, some crossing block borders.
      while (stim_words.size() < ITEM_TARGET) begin
         msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 130)
                                               : $urandom_range(0, 20);
         if (msg_len > ITEM_TARGET - stim_words.size())
            msg_len = ITEM_TARGET - stim_words.size();
         add_message(msg_len, 1'b1);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_words[k]) begin
         // Once, the sender waits until every expected digest word is in.
         if (k == 9) begin
            req_valid <= 1'b0;
            wait (digest_queue.size() == 0);
            @(posedge clock);
         end
         gap = $urandom_range(0, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rw = stim_words[k];
         req_valid      <= 1'b1;
         req_data_byte  <= rw.data_byte;
         req_byte_valid <= rw.byte_valid;
         req_last       <= rw.last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         predict_digest(rw);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Receiver: random stalls, then compares each digest word to the oldest
   // expectation.
   initial begin
      digest_word_type exp_w;
      int              stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (digest_queue.size() == 0) begin
            $error("digest word %h arrived with none expected", rsp_digest_word);
            fail_count++;
         end else begin
            exp_w = digest_queue.pop_front();
            if (rsp_digest_word !== exp_w.digest_word) begin
               $error("digest_word: expected %h, actual %h",
                      exp_w.digest_word, rsp_digest_word);
               fail_count++;
            end
            if (rsp_word_index !== exp_w.word_index) begin
               $error("word_index: expected %0d, actual %0d",
                      exp_w.word_index, rsp_word_index);
               fail_count++;
            end
            if (rsp_last_word !== exp_w.last_word) begin
               $error("last_word: expected %0b, actual %0b",
                      exp_w.last_word, rsp_last_word);
               fail_count++;
            end
         end
      end
   end

   // End of run: all stimulus taken, all digests in, then a short drain
   // so any stray extra word would still be caught.
   initial begin
      wait (stim_done);
      wait (digest_queue.size() == 0);
      repeat (600) @(posedge clock);
      if (fail_count == 0 && digest_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/sha_pkg.sv
hw/rtl/sha_ram.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_stream_hasher_unit.sv
verif/tb.sv
